### hdl/command_packet_framer_crc8_defines.svh
// ----------------------------------------------------------------------------
// command packet framer assertion macros
// shared concurrent assertion forms, clocked on aclk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef COMMAND_PACKET_FRAMER_CRC8_DEFINES_SVH
`define COMMAND_PACKET_FRAMER_CRC8_DEFINES_SVH

// same-cycle implication
`define CPF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CPF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/cpfcrc8_pkg.sv
// ----------------------------------------------------------------------------
// cpfcrc8_pkg
// constants, command/status types and crc-8 step for the packet framer
// ----------------------------------------------------------------------------
package cpfcrc8_pkg;

    localparam logic [7:0] HDR0        = 8'hAA;
    localparam logic [7:0] HDR1        = 8'h55;
    localparam logic [7:0] LEN_ONE     = 8'h01;
    localparam logic [7:0] LEN_TWO     = 8'h02;
    localparam logic [7:0] CMD_SETFREQ = 8'h09;
    localparam logic [7:0] CRC_POLY    = 8'hD5;

    localparam int unsigned POS_W = 3;

    // byte positions within a packet
    localparam logic [POS_W-1:0] POS_HDR0  = 3'd0;
    localparam logic [POS_W-1:0] POS_HDR1  = 3'd1;
    localparam logic [POS_W-1:0] POS_CMD   = 3'd2;
    localparam logic [POS_W-1:0] POS_LEN   = 3'd3;
    localparam logic [POS_W-1:0] POS_PAY0  = 3'd4;
    localparam logic [POS_W-1:0] POS_CRC1  = 3'd5;
    localparam logic [POS_W-1:0] POS_CRC2  = 3'd6;

    typedef struct packed {
        logic             capture;
        logic             emit;
        logic             crc_sel;
        logic [POS_W-1:0] pos;
    } cmd_t;

    typedef struct packed {
        logic held_mode;
    } status_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### hdl/cpfcrc8_ctrl.sv
// ----------------------------------------------------------------------------
// cpfcrc8_ctrl
// sequencer: request handshake, byte position, output beat valid
// ----------------------------------------------------------------------------
module cpfcrc8_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  cpfcrc8_pkg::status_t status,
    output cpfcrc8_pkg::cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEND = 1'b1;

    logic                            state_reg, state_next;
    logic [cpfcrc8_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                            m_valid_reg, m_valid_next;
    logic                            load_ok;
    logic                            emit;
    logic                            crc_pos;
    logic                            capture;
    logic [cpfcrc8_pkg::POS_W-1:0]   last_pos;

    always_comb begin
        load_ok  = !m_valid_reg || m_ready;
        emit     = (state_reg == ST_SEND) && load_ok;
        last_pos = status.held_mode ? cpfcrc8_pkg::POS_CRC2 : cpfcrc8_pkg::POS_CRC1;
        crc_pos  = (pos_reg == last_pos);
        s_ready  = (state_reg == ST_IDLE) || (emit && crc_pos);
        capture  = s_valid && s_ready;

        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        pos_next = pos_reg;
        if (capture) begin
            pos_next = cpfcrc8_pkg::POS_HDR0;
        end else if (emit) begin
            pos_next = pos_reg + 3'd1;
        end

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (capture) state_next = ST_SEND;
            end
            ST_SEND: begin
                if (emit && crc_pos && !capture) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= cpfcrc8_pkg::POS_HDR0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign cmd.capture = capture;
    assign cmd.emit    = emit;
    assign cmd.crc_sel = crc_pos;
    assign cmd.pos     = pos_reg;

endmodule

### hdl/cpfcrc8_dp.sv
// ----------------------------------------------------------------------------
// cpfcrc8_dp
// datapath: held request, byte select, running crc, output beat register
// ----------------------------------------------------------------------------
module cpfcrc8_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cpfcrc8_pkg::cmd_t    cmd,
    output cpfcrc8_pkg::status_t status,
    input  logic                 s_mode,
    input  logic [7:0]           s_command,
    input  logic [15:0]          s_value,
    output logic [7:0]           m_packet_byte,
    output logic                 m_last
);

    logic        held_mode_reg;
    logic [7:0]  held_command_reg;
    logic [15:0] held_value_reg;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [7:0]  body;
    logic [7:0]  crc_base;

    always_comb begin
        unique case (cmd.pos)
            cpfcrc8_pkg::POS_HDR0: body = cpfcrc8_pkg::HDR0;
            cpfcrc8_pkg::POS_HDR1: body = cpfcrc8_pkg::HDR1;
            cpfcrc8_pkg::POS_CMD:  body = held_mode_reg ? cpfcrc8_pkg::CMD_SETFREQ
                                                        : held_command_reg;
            cpfcrc8_pkg::POS_LEN:  body = held_mode_reg ? cpfcrc8_pkg::LEN_TWO
                                                        : cpfcrc8_pkg::LEN_ONE;
            cpfcrc8_pkg::POS_PAY0: body = held_mode_reg ? held_value_reg[15:8]
                                                        : held_value_reg[7:0];
            default:               body = held_value_reg[7:0];
        endcase
        crc_base = (cmd.pos == cpfcrc8_pkg::POS_HDR0) ? 8'h00 : crc_reg;
        crc_next = cpfcrc8_pkg::crc8_update(crc_base, body);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_mode_reg <= 1'b0;
            crc_reg       <= 8'h00;
        end else begin
            if (cmd.capture) held_mode_reg <= s_mode;
            if (cmd.emit && !cmd.crc_sel) crc_reg <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            held_command_reg <= s_command;
            held_value_reg   <= s_value;
        end
        if (cmd.emit) begin
            byte_reg <= cmd.crc_sel ? crc_reg : body;
            last_reg <= cmd.crc_sel;
        end
    end

    assign status.held_mode = held_mode_reg;
    assign m_packet_byte    = byte_reg;
    assign m_last           = last_reg;

endmodule

### hdl/command_packet_framer_crc8.sv
// start: the request is registered, then HDR0 is loaded as the first beat
// throughput: one beat per cycle through the output register while m_ready
//   allows; a request is 6 beats (one-byte payload) or 7 (set-frequency);
//   the next request is taken in the cycle the crc beat is loaded
// reset: synchronous active-low aresetn clears the sequencer, crc and output
//   valid; the block is ready for a request right after reset
// ----------------------------------------------------------------------------
// command_packet_framer_crc8
// frames one control request into a serial command packet with crc-8 (0xd5)
// ----------------------------------------------------------------------------
`include "command_packet_framer_crc8_defines.svh"

module command_packet_framer_crc8 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_command,
    input  logic [15:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_packet_byte,
    output logic        m_last
);

    cpfcrc8_pkg::cmd_t    cmd;
    cpfcrc8_pkg::status_t status;

    cpfcrc8_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cpfcrc8_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_mode        (s_mode),
        .s_command     (s_command),
        .s_value       (s_value),
        .m_packet_byte (m_packet_byte),
        .m_last        (m_last)
    );

    // last flag marks exactly the crc beat
    `CPF_ASSERT_NEXT(a_last_on_crc, cmd.emit, m_last == $past(cmd.crc_sel))
    // while busy the byte position stays inside the packet
    `CPF_ASSERT_SAME(a_pos_range, !s_ready, cmd.pos <= cpfcrc8_pkg::POS_CRC2)
    // a new request always starts at the first header byte
    `CPF_ASSERT_NEXT(a_start_hdr, s_valid && s_ready, cmd.pos == cpfcrc8_pkg::POS_HDR0)

endmodule

### dv/tb_command_packet_framer_crc8.sv
// ----------------------------------------------------------------------------
// tb_command_packet_framer_crc8
// The bench drives control requests into the framer and compares every packet
// beat with a CRC-8 packet builder kept in the bench. The run covers directed
// corner requests, back-to-back traffic, a long receiver hold-off, and random
// requests with idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_command_packet_framer_crc8;

    localparam logic MODE_ONE_BYTE = 1'b0;
    localparam logic MODE_SETFREQ  = 1'b1;
    localparam int CYCLE_LIMIT     = 60000;
    localparam int HOLDOFF_CYCLES  = 90;
    localparam int DRAIN_CYCLES    = 16;
    localparam int IDLE_PERCENT    = 11;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } packet_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_mode = 1'b0;
    logic [7:0]  s_command = 8'h00;
    logic [15:0] s_value = 16'h0000;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_packet_byte;
    logic        m_last;

    packet_beat_t pending_beats[$];
    int  mismatch_count = 0;
    int  beats_checked = 0;
    int  one_byte_requests = 0;
    int  setfreq_requests = 0;
    int  cycle_count = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    bit  hold_req = 1'b0;
    bit  hold_ack = 1'b0;
    int  hold_left = 0;

    command_packet_framer_crc8 u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_command     (s_command),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packet_byte (m_packet_byte),
        .m_last        (m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still pending",
                     cycle_count, pending_beats.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // bit-serial crc-8, poly 0xd5, msb first
    function automatic logic [7:0] crc8_dvb_s2(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ data[i];
            r = {r[6:0], 1'b0} ^ (fb ? cpfcrc8_pkg::CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    function automatic void frame_request(input logic mode, input logic [7:0] command,
                                          input logic [15:0] value);
        logic [7:0] body[$];
        logic [7:0] crc;
        packet_beat_t beat;
        body = {cpfcrc8_pkg::HDR0, cpfcrc8_pkg::HDR1};
        if (mode == MODE_SETFREQ) begin
            body.push_back(cpfcrc8_pkg::CMD_SETFREQ);
            body.push_back(cpfcrc8_pkg::LEN_TWO);
            body.push_back(value[15:8]);
            body.push_back(value[7:0]);
            setfreq_requests++;
        end else begin
            body.push_back(command);
            body.push_back(cpfcrc8_pkg::LEN_ONE);
            body.push_back(value[7:0]);
            one_byte_requests++;
        end
        crc = 8'h00;
        foreach (body[i]) begin
            crc = crc8_dvb_s2(crc, body[i]);
            beat.data = body[i];
            beat.last = 1'b0;
            pending_beats.push_back(beat);
        end
        beat.data = crc;
        beat.last = 1'b1;
        pending_beats.push_back(beat);
    endfunction

    function automatic void note_failure(input string msg);
        if (mismatch_count < REPORT_LIMIT) begin
            $display("[%0d] %s", cycle_count, msg);
        end
        mismatch_count++;
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= HOLDOFF_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(rx_idle_on && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    // beat checker
    always @(posedge aclk) begin
        packet_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_beats.size() == 0) begin
                note_failure($sformatf("unexpected beat: byte=%02h last=%0b",
                                       m_packet_byte, m_last));
            end else begin
                want = pending_beats.pop_front();
                if (m_packet_byte !== want.data) begin
                    note_failure($sformatf("packet_byte mismatch: expected %02h, actual %02h",
                                           want.data, m_packet_byte));
                end
                if (m_last !== want.last) begin
                    note_failure($sformatf("last mismatch: expected %0b, actual %0b",
                                           want.last, m_last));
                end
                beats_checked++;
            end
        end
    end

    // called at a rising edge; returns at the edge that accepts the request
    task automatic send_request(input logic mode, input logic [7:0] command,
                                input logic [15:0] value);
        if (tx_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            do begin
                @(posedge aclk);
            end while ($urandom_range(99) < IDLE_PERCENT);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_command <= command;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        frame_request(mode, command, value);
    endtask

    task automatic send_random_request();
        logic [15:0] value;
        case ($urandom_range(9))
            0: value = 16'h0000;
            1: value = 16'hFFFF;
            default: value = 16'($urandom);
        endcase
        send_request($urandom_range(1, 0) ? MODE_SETFREQ : MODE_ONE_BYTE, 8'($urandom),
                     value);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_beats.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic test_directed_packets();
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
        send_request(MODE_ONE_BYTE, 8'h00, 16'h0000);
        send_request(MODE_ONE_BYTE, 8'hFF, 16'hFFFF);
        send_request(MODE_ONE_BYTE, 8'h01, 16'hFF00);
        send_request(MODE_ONE_BYTE, 8'h80, 16'h00FF);
        send_request(MODE_ONE_BYTE, cpfcrc8_pkg::CMD_SETFREQ, 16'h1234);
        send_request(MODE_ONE_BYTE, cpfcrc8_pkg::HDR0, {8'h00, cpfcrc8_pkg::HDR1});
        send_request(MODE_ONE_BYTE, 8'h5A, 16'hA5A5);
        send_request(MODE_SETFREQ, 8'h00, 16'h0000);
        send_request(MODE_SETFREQ, 8'hFF, 16'hFFFF);
        send_request(MODE_SETFREQ, 8'h33, 16'h8001);
        send_request(MODE_SETFREQ, cpfcrc8_pkg::CMD_SETFREQ, 16'h00FF);
        send_request(MODE_SETFREQ, 8'hC3, 16'hFF00);
        send_request(MODE_SETFREQ, 8'h7E, 16'd5800);
        send_request(MODE_SETFREQ, 8'h01, 16'h7FFE);
        send_request(MODE_ONE_BYTE, 8'h7F, 16'h0080);
        wait_drained();
    endtask

    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        repeat (25) send_random_request();
        wait_drained();
    endtask

    task automatic test_receiver_holdoff();
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b1;
        hold_req <= ~hold_req;
        repeat (10) send_random_request();
        wait_drained();
    endtask

    task automatic test_random_requests();
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
        repeat (100) send_random_request();
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_packets();
        test_back_to_back();
        test_receiver_holdoff();
        test_random_requests();

        $display("sent %0d one-byte commands and %0d set-frequency requests, %0d beats checked",
                 one_byte_requests, setfreq_requests, beats_checked);
        $display("traffic ran back to back, with random idles, and behind a %0d-cycle stall",
                 HOLDOFF_CYCLES);
        if (mismatch_count == 0 && pending_beats.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/cpfcrc8_pkg.sv
hdl/cpfcrc8_ctrl.sv
hdl/cpfcrc8_dp.sv
hdl/command_packet_framer_crc8.sv
dv/tb_command_packet_framer_crc8.sv
